### design/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and microprogram encoding for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int PC_W            = 4;

    typedef logic [PC_W-1:0] pc_t;

    // ASCII characters recognized by the converter.
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_CARET  = 8'h5E;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNMATCHED = 2'd2;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_marker;
    } infix_t;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic [1:0] status;
        logic       last;
    } postfix_t;

    // Operator stack entry codes.
    typedef enum logic [2:0] {
        OP_LPAREN = 3'd0,
        OP_PLUS   = 3'd1,
        OP_MINUS  = 3'd2,
        OP_STAR   = 3'd3,
        OP_SLASH  = 3'd4,
        OP_CARET  = 3'd5
    } op_code_t;

    // Branch conditions of the microprogram.
    typedef enum logic [2:0] {
        C_NEVER,
        C_EMPTY,
        C_FULL,
        C_TOP_LP,
        C_OP_STOP
    } cond_t;

    // Datapath actions of the microprogram.
    typedef enum logic [2:0] {
        A_NOP,
        A_EMIT_SYM,
        A_EMIT_OVF,
        A_EMIT_UNM,
        A_POP_EMIT,
        A_POP,
        A_PUSH,
        A_DONE
    } act_t;

    // When the condition holds the step jumps to jt and does nothing else;
    // otherwise it performs act and continues at nx.
    typedef struct packed {
        cond_t cond;
        pc_t   jt;
        act_t  act;
        pc_t   nx;
    } ucode_t;

    // Microprogram entry points and labels.
    localparam pc_t PC_DIGIT    = 4'd0;
    localparam pc_t PC_PUSH     = 4'd1;
    localparam pc_t PC_OVF      = 4'd2;
    localparam pc_t PC_OP       = 4'd3;
    localparam pc_t PC_RP       = 4'd4;
    localparam pc_t PC_RP_LOOP  = 4'd5;
    localparam pc_t PC_UNM      = 4'd6;
    localparam pc_t PC_RP_DROP  = 4'd7;
    localparam pc_t PC_END      = 4'd8;
    localparam pc_t PC_END_LOOP = 4'd9;
    localparam pc_t PC_END_DROP = 4'd10;
    localparam pc_t PC_DONE     = 4'd11;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic load;
        logic fire;
        act_t act;
    } dp_ctrl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic empty;
        logic full;
        logic top_lp;
        logic op_stop;
        logic pend_v;
        logic out_free;
    } dp_flags_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    function automatic op_code_t op_code(input logic [7:0] c);
        op_code_t r;
        case (c)
            CH_PLUS:  r = OP_PLUS;
            CH_MINUS: r = OP_MINUS;
            CH_STAR:  r = OP_STAR;
            CH_SLASH: r = OP_SLASH;
            CH_CARET: r = OP_CARET;
            default:  r = OP_LPAREN;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] code_char(input op_code_t c);
        logic [7:0] r;
        case (c)
            OP_LPAREN: r = CH_LPAREN;
            OP_PLUS:   r = CH_PLUS;
            OP_MINUS:  r = CH_MINUS;
            OP_STAR:   r = CH_STAR;
            OP_SLASH:  r = CH_SLASH;
            OP_CARET:  r = CH_CARET;
            default:   r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] code_level(input op_code_t c);
        logic [1:0] r;
        case (c)
            OP_PLUS, OP_MINUS: r = 2'd1;
            OP_STAR, OP_SLASH: r = 2'd2;
            OP_CARET:          r = 2'd3;
            default:           r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic pc_t entry_pc(input infix_t w);
        pc_t r;
        if (w.end_marker)
            r = PC_END;
        else if (w.symbol >= CH_ZERO && w.symbol <= CH_NINE)
            r = PC_DIGIT;
        else if (w.symbol == CH_LPAREN)
            r = PC_PUSH;
        else if (w.symbol == CH_RPAREN)
            r = PC_RP;
        else if (op_code(w.symbol) != OP_LPAREN)
            r = PC_OP;
        else
            r = PC_DONE;
        return r;
    endfunction

endpackage

### design/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an infix expression, one character per word,
// into postfix order under a small microprogram.
// ----------------------------------------------------------------------------
// The infix channel takes one word per character: an ASCII symbol, or an end
// marker that flushes the operator stack. The postfix channel returns zero or
// more words per input word, each carrying a digit or operator, a status and
// a last flag on the final word that the input caused. Both channels use a
// valid/ready handshake.
// An input word is taken only while the sequencer is idle. The sequencer then
// runs one microprogram step per cycle, unless it pauses for a stalled output,
// until it is idle again. A digit or an open parenthesis takes two steps and
// an ignored character one. An operator takes three steps plus one for each
// operator it pops, and an overflow adds one step. A closing parenthesis takes
// two steps per operator it pops plus four, or plus three when it finds no
// partner. The end marker takes two steps per operator and three per open
// parenthesis it flushes, plus two. A digit passes through the holding
// register and then the output register on its way to the postfix channel.
// Reset empties the operator stack and drops any word in flight. When the
// receiver stalls, the output register holds its word, one more word waits
// in a holding register, and the sequencer pauses on its next emit or done step.
// Stack overflow or an unmatched closing parenthesis yields a final word with
// a zero symbol and an error status.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               infix_valid,
    output logic               infix_ready,
    input  itp_pkg::infix_t    infix_word,
    output logic               postfix_valid,
    input  logic               postfix_ready,
    output itp_pkg::postfix_t  postfix_word
);
    import itp_pkg::*;

    dp_ctrl_t  ctrl;
    dp_flags_t flags;

    // The sequencer walks the microprogram and decides each step's action.
    itp_sequencer u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .infix_valid (infix_valid),
        .infix_word  (infix_word),
        .infix_ready (infix_ready),
        .flags       (flags),
        .ctrl        (ctrl)
    );

    // The datapath owns the stack, the held word and the output register.
    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .infix_word    (infix_word),
        .ctrl          (ctrl),
        .flags         (flags),
        .postfix_valid (postfix_valid),
        .postfix_ready (postfix_ready),
        .postfix_word  (postfix_word)
    );

endmodule

### design/itp_ucode_rom.sv
// ----------------------------------------------------------------------------
// itp_ucode_rom
// Read-only microprogram of the converter, one control word per step.
// ----------------------------------------------------------------------------
module itp_ucode_rom (
    input  itp_pkg::pc_t    pc,
    output itp_pkg::ucode_t uword
);
    import itp_pkg::*;

    always_comb
    begin
        case (pc)
            // Digit: pass it straight through.
            PC_DIGIT:    uword = '{C_NEVER,   PC_DONE,     A_EMIT_SYM, PC_DONE};
            // Push the latched code, or report overflow when full.
            PC_PUSH:     uword = '{C_FULL,    PC_OVF,      A_PUSH,     PC_DONE};
            PC_OVF:      uword = '{C_NEVER,   PC_DONE,     A_EMIT_OVF, PC_DONE};
            // Operator: pop while the top binds at least as tightly.
            PC_OP:       uword = '{C_OP_STOP, PC_PUSH,     A_POP_EMIT, PC_OP};
            // Closing parenthesis: pop down to the matching open one.
            PC_RP:       uword = '{C_EMPTY,   PC_UNM,      A_NOP,      PC_RP_LOOP};
            PC_RP_LOOP:  uword = '{C_TOP_LP,  PC_RP_DROP,  A_POP_EMIT, PC_RP};
            PC_UNM:      uword = '{C_NEVER,   PC_DONE,     A_EMIT_UNM, PC_DONE};
            PC_RP_DROP:  uword = '{C_NEVER,   PC_DONE,     A_POP,      PC_DONE};
            // End of expression: flush, dropping open parentheses.
            PC_END:      uword = '{C_EMPTY,   PC_DONE,     A_NOP,      PC_END_LOOP};
            PC_END_LOOP: uword = '{C_TOP_LP,  PC_END_DROP, A_POP_EMIT, PC_END};
            PC_END_DROP: uword = '{C_NEVER,   PC_DONE,     A_POP,      PC_END};
            default:     uword = '{C_NEVER,   PC_DONE,     A_DONE,     PC_DONE};
        endcase
    end

endmodule

### design/itp_sequencer.sv
// ----------------------------------------------------------------------------
// itp_sequencer
// Step counter and branch logic that walks the microprogram for each word.
// ----------------------------------------------------------------------------
module itp_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                infix_valid,
    input  itp_pkg::infix_t     infix_word,
    output logic                infix_ready,
    input  itp_pkg::dp_flags_t  flags,
    output itp_pkg::dp_ctrl_t   ctrl
);
    import itp_pkg::*;

    seq_state_t state_reg, state_next;
    pc_t        pc_reg, pc_next;
    ucode_t     uword;
    logic       cond_true;
    logic       needs_out;
    logic       stall;
    logic       accept;

    itp_ucode_rom u_rom (
        .pc    (pc_reg),
        .uword (uword)
    );

    always_comb
    begin
        case (uword.cond)
            C_EMPTY:   cond_true = flags.empty;
            C_FULL:    cond_true = flags.full;
            C_TOP_LP:  cond_true = flags.top_lp;
            C_OP_STOP: cond_true = flags.op_stop;
            default:   cond_true = 1'b0;
        endcase
    end

    // Any action that may move the held word to the output register.
    assign needs_out = (uword.act == A_EMIT_SYM) || (uword.act == A_EMIT_OVF) ||
                       (uword.act == A_EMIT_UNM) || (uword.act == A_POP_EMIT) ||
                       (uword.act == A_DONE);
    assign stall     = needs_out && flags.pend_v && !flags.out_free;

    // Next state and step counter.
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (infix_valid)
                begin
                    state_next = SEQ_RUN;
                    pc_next    = entry_pc(infix_word);
                end
            end
            SEQ_RUN:
            begin
                if (cond_true)
                    pc_next = uword.jt;
                else if (!stall)
                begin
                    pc_next = uword.nx;
                    if (uword.act == A_DONE)
                        state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        infix_ready = 1'b0;
        ctrl.fire   = 1'b0;
        case (state_reg)
            SEQ_IDLE: infix_ready = 1'b1;
            SEQ_RUN:  ctrl.fire   = !cond_true && !stall;
            default:  infix_ready = 1'b0;
        endcase
        accept    = infix_valid && infix_ready;
        ctrl.load = accept;
        ctrl.act  = uword.act;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            pc_reg    <= PC_DONE;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

### design/itp_datapath.sv
// ----------------------------------------------------------------------------
// itp_datapath
// Operator stack, held result word and output register driven by the
// microprogram's actions.
// ----------------------------------------------------------------------------
module itp_datapath #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  itp_pkg::infix_t     infix_word,
    input  itp_pkg::dp_ctrl_t   ctrl,
    output itp_pkg::dp_flags_t  flags,
    output logic                postfix_valid,
    input  logic                postfix_ready,
    output itp_pkg::postfix_t   postfix_word
);
    import itp_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    op_code_t          stack_mem [STACK_DEPTH];
    op_code_t          top_reg;
    logic [7:0]        sym_reg;
    op_code_t          code_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     count_m1;
    logic              pend_v_reg, pend_v_next;
    logic [7:0]        pend_sym_reg, pend_sym_next;
    logic [1:0]        pend_st_reg, pend_st_next;
    logic              out_v_reg, out_v_next;
    postfix_t          out_reg, out_next;
    logic              do_push;
    logic              do_pop;
    logic              do_emit;
    logic              do_done;
    logic [7:0]        emit_sym;
    logic [1:0]        emit_st;

    assign do_push = ctrl.fire && (ctrl.act == A_PUSH);
    assign do_pop  = ctrl.fire && ((ctrl.act == A_POP) || (ctrl.act == A_POP_EMIT));
    assign do_emit = ctrl.fire && ((ctrl.act == A_EMIT_SYM) || (ctrl.act == A_EMIT_OVF) ||
                                   (ctrl.act == A_EMIT_UNM) || (ctrl.act == A_POP_EMIT));
    assign do_done = ctrl.fire && (ctrl.act == A_DONE);

    always_comb
    begin
        case (ctrl.act)
            A_EMIT_SYM:
            begin
                emit_sym = sym_reg;
                emit_st  = ST_OK;
            end
            A_EMIT_OVF:
            begin
                emit_sym = 8'd0;
                emit_st  = ST_OVERFLOW;
            end
            A_EMIT_UNM:
            begin
                emit_sym = 8'd0;
                emit_st  = ST_UNMATCHED;
            end
            default:
            begin
                emit_sym = code_char(top_reg);
                emit_st  = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
            count_next = count_reg + 1'b1;
        else if (do_pop)
            count_next = count_reg - 1'b1;
    end

    assign count_m1 = count_next - 1'b1;

    // The newest result is held back until the next result or the done step so
    // that its last flag is known when it moves to the output register.
    always_comb
    begin
        pend_v_next   = pend_v_reg;
        pend_sym_next = pend_sym_reg;
        pend_st_next  = pend_st_reg;
        out_next      = out_reg;
        out_v_next    = out_v_reg && !postfix_ready;
        if (do_emit)
        begin
            pend_v_next   = 1'b1;
            pend_sym_next = emit_sym;
            pend_st_next  = emit_st;
        end
        else if (do_done)
        begin
            pend_v_next = 1'b0;
        end
        if ((do_emit || do_done) && pend_v_reg)
        begin
            out_v_next          = 1'b1;
            out_next.out_symbol = pend_sym_reg;
            out_next.status     = pend_st_reg;
            out_next.last       = do_done;
        end
    end

    // Stack storage with a registered top-of-stack read.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            stack_mem[count_reg[AW-1:0]] <= code_reg;
            top_reg                      <= code_reg;
        end
        else if (count_next != '0)
        begin
            top_reg <= stack_mem[count_m1[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sym_reg  <= infix_word.symbol;
            code_reg <= op_code(infix_word.symbol);
        end
        pend_sym_reg <= pend_sym_next;
        pend_st_reg  <= pend_st_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    assign flags.empty    = (count_reg == '0);
    assign flags.full     = (count_reg == CW'(STACK_DEPTH));
    assign flags.top_lp   = (top_reg == OP_LPAREN);
    assign flags.op_stop  = flags.empty || flags.top_lp ||
                            (code_level(top_reg) < code_level(code_reg));
    assign flags.pend_v   = pend_v_reg;
    assign flags.out_free = !out_v_reg || postfix_ready;

    assign postfix_valid = out_v_reg;
    assign postfix_word  = out_reg;

endmodule

### design/itp_checker.sv
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks on the converter's channels.
// ----------------------------------------------------------------------------
module itp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               infix_valid,
    input logic               infix_ready,
    input logic               postfix_valid,
    input logic               postfix_ready,
    input itp_pkg::postfix_t  postfix_word
);
    import itp_pkg::*;

    // A stalled output word stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        postfix_valid && !postfix_ready |=> postfix_valid && $stable(postfix_word))
        else $error("postfix word changed while stalled");

    // An accepted input word keeps the sequencer busy in the cycle after it is taken.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        infix_valid && infix_ready |=> !infix_ready)
        else $error("input taken again right after a word");

    // An error word carries no symbol.
    a_err_sym: assert property (@(posedge clk) disable iff (!rst_n)
        postfix_valid && postfix_word.status != ST_OK |-> postfix_word.out_symbol == 8'd0)
        else $error("error word with nonzero symbol");

    // An error ends the results of its input word.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        postfix_valid && postfix_word.status != ST_OK |-> postfix_word.last)
        else $error("error word not marked last");

    // A good word is a digit or an operator.
    a_ok_sym: assert property (@(posedge clk) disable iff (!rst_n)
        postfix_valid && postfix_word.status == ST_OK |->
            (postfix_word.out_symbol >= CH_ZERO && postfix_word.out_symbol <= CH_NINE) ||
            postfix_word.out_symbol == CH_PLUS || postfix_word.out_symbol == CH_MINUS ||
            postfix_word.out_symbol == CH_STAR || postfix_word.out_symbol == CH_SLASH ||
            postfix_word.out_symbol == CH_CARET)
        else $error("postfix word is neither digit nor operator");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);

### test/infix_to_postfix_converter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb
// Self-checking bench for the shunting-yard infix to postfix converter.
// ----------------------------------------------------------------------------
// Character words go in on the infix channel and the bench keeps its own
// operator stack to predict every postfix word, including the overflow and
// unmatched-parenthesis error words. A directed block comes first, then
// random expressions, broken expressions, deep nesting and noise, with
// random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb;

    import itp_pkg::*;

    localparam int OP_STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_WORDS   = 360;
    localparam int CALM_AFTER     = 300;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;

    // An error word carries no character.
    localparam logic [7:0] NO_SYMBOL = 8'h00;

    // Shadow of the converter: its own operator stack plus the queue of
    // postfix words that are still owed by the block.
    class postfix_checker;
        op_code_t    op_stack[OP_STACK_DEPTH];
        int unsigned op_depth;
        postfix_t    pending_postfix[$];
        int unsigned failures;

        function new();
            op_depth = 0;
            failures = 0;
        endfunction

        function int unsigned rank(op_code_t c);
            case (c)
                OP_CARET:          return 3;
                OP_STAR, OP_SLASH: return 2;
                OP_PLUS, OP_MINUS: return 1;
                default:           return 0;
            endcase
        endfunction

        function logic [7:0] op_char(op_code_t c);
            case (c)
                OP_PLUS:  return CH_PLUS;
                OP_MINUS: return CH_MINUS;
                OP_STAR:  return CH_STAR;
                OP_SLASH: return CH_SLASH;
                OP_CARET: return CH_CARET;
                default:  return CH_LPAREN;
            endcase
        endfunction

        function postfix_t make_word(logic [7:0] ch, logic [1:0] st);
            postfix_t p;
            p.out_symbol = ch;
            p.status     = st;
            p.last       = 1'b0;
            return p;
        endfunction

        // Works out every postfix word caused by one accepted infix word.
        function void convert_symbol(infix_t w);
            postfix_t burst[$];
            op_code_t top;
            op_code_t code;
            bit       is_op;
            bit       push_it;
            bit       matched;
            code    = OP_LPAREN;
            is_op   = 1'b1;
            push_it = 1'b0;
            matched = 1'b0;
            case (w.symbol)
                CH_PLUS:  code = OP_PLUS;
                CH_MINUS: code = OP_MINUS;
                CH_STAR:  code = OP_STAR;
                CH_SLASH: code = OP_SLASH;
                CH_CARET: code = OP_CARET;
                default:  is_op = 1'b0;
            endcase

            if (w.end_marker)
            begin
                // Flush; open parentheses vanish without a word.
                while (op_depth > 0)
                begin
                    op_depth--;
                    top = op_stack[op_depth];
                    if (top != OP_LPAREN)
                        burst.push_back(make_word(op_char(top), ST_OK));
                end
            end
            else if (w.symbol >= CH_ZERO && w.symbol <= CH_NINE)
            begin
                burst.push_back(make_word(w.symbol, ST_OK));
            end
            else if (w.symbol == CH_LPAREN)
            begin
                push_it = 1'b1;
            end
            else if (w.symbol == CH_RPAREN)
            begin
                while (op_depth > 0 && !matched)
                begin
                    op_depth--;
                    top = op_stack[op_depth];
                    if (top == OP_LPAREN)
                        matched = 1'b1;
                    else
                        burst.push_back(make_word(op_char(top), ST_OK));
                end
                // Without a partner, the whole stack has been emptied by now.
                if (!matched)
                    burst.push_back(make_word(NO_SYMBOL, ST_UNMATCHED));
            end
            else if (is_op)
            begin
                // Left associative: pop everything of equal or higher rank.
                while (op_depth > 0 && op_stack[op_depth-1] != OP_LPAREN &&
                       rank(op_stack[op_depth-1]) >= rank(code))
                begin
                    op_depth--;
                    burst.push_back(make_word(op_char(op_stack[op_depth]), ST_OK));
                end
                push_it = 1'b1;
            end

            if (push_it)
            begin
                if (op_depth >= OP_STACK_DEPTH)
                begin
                    burst.push_back(make_word(NO_SYMBOL, ST_OVERFLOW));
                end
                else
                begin
                    op_stack[op_depth] = code;
                    op_depth++;
                end
            end

            if (burst.size() > 0)
                burst[burst.size()-1].last = 1'b1;
            foreach (burst[i])
                pending_postfix.push_back(burst[i]);
        endfunction

        function void check_postfix(postfix_t got);
            postfix_t want;
            if (pending_postfix.size() == 0)
            begin
                $error("unexpected postfix word %h", got);
                failures++;
                return;
            end
            want = pending_postfix.pop_front();
            if (got.out_symbol !== want.out_symbol)
            begin
                $error("out_symbol: expected %h, got %h", want.out_symbol, got.out_symbol);
                failures++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     infix_valid = 1'b0;
    logic     infix_ready;
    infix_t   infix_word = '0;
    logic     postfix_valid;
    logic     postfix_ready = 1'b0;
    postfix_t postfix_word;

    postfix_checker postfix_model;

    logic [7:0]  expr_chars[$];
    logic [7:0]  op_chars[5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
    int unsigned words_sent = 0;
    int unsigned out_hold = 0;
    int unsigned idle_cycles = 0;
    bit          calm = 1'b0;
    bit          no_gaps = 1'b0;

    always #5 clk = ~clk;

    infix_to_postfix_converter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .infix_valid   (infix_valid),
        .infix_ready   (infix_ready),
        .infix_word    (infix_word),
        .postfix_valid (postfix_valid),
        .postfix_ready (postfix_ready),
        .postfix_word  (postfix_word)
    );

    // Offers one word and returns at the edge that takes it. Valid is left
    // high so the next word can follow back to back; a random gap drops it.
    task automatic send_word(input infix_t w);
        infix_word  <= w;
        infix_valid <= 1'b1;
        do
            @(posedge clk);
        while (!infix_ready);
        postfix_model.convert_symbol(w);
        words_sent++;
        if (!calm && !no_gaps && $urandom_range(0, 5) == 0)
        begin
            infix_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic send_char(input logic [7:0] c);
        infix_t w;
        w.symbol     = c;
        w.end_marker = 1'b0;
        send_word(w);
    endtask

    // The symbol bits ride along with an end marker and must be ignored.
    task automatic send_end(input logic [7:0] junk);
        infix_t w;
        w.symbol     = junk;
        w.end_marker = 1'b1;
        send_word(w);
    endtask

    // Drops valid and waits until every owed postfix word has been taken.
    task automatic wait_drained();
        infix_valid <= 1'b0;
        while (postfix_model.pending_postfix.size() > 0)
            @(posedge clk);
    endtask

    // Builds a random expression into expr_chars. A well-formed one always
    // alternates operand and operator and closes every parenthesis; a broken
    // one may throw in stray closing parentheses or leave some open.
    task automatic make_expression(input int max_len, input bit broken);
        int open_cnt;
        bit want_operand;
        expr_chars.delete();
        open_cnt     = 0;
        want_operand = 1'b1;
        forever
        begin
            if (want_operand)
            begin
                if (open_cnt < 6 && expr_chars.size() < max_len &&
                    $urandom_range(0, 3) == 0)
                begin
                    expr_chars.push_back(CH_LPAREN);
                    open_cnt++;
                end
                else
                begin
                    expr_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    want_operand = 1'b0;
                end
            end
            else
            begin
                if (expr_chars.size() >= max_len &&
                    (open_cnt == 0 || (broken && $urandom_range(0, 1) == 0)))
                    break;
                if (broken && $urandom_range(0, 7) == 0)
                begin
                    expr_chars.push_back(CH_RPAREN);
                    if (open_cnt > 0)
                        open_cnt--;
                end
                else if (open_cnt > 0 &&
                         (expr_chars.size() >= max_len || $urandom_range(0, 2) == 0))
                begin
                    expr_chars.push_back(CH_RPAREN);
                    open_cnt--;
                end
                else
                begin
                    expr_chars.push_back(op_chars[$urandom_range(0, 4)]);
                    want_operand = 1'b1;
                end
            end
        end
    endtask

    task automatic send_expression();
        foreach (expr_chars[i])
            send_char(expr_chars[i]);
        send_end(8'($urandom_range(0, 255)));
    endtask

    // Receiver: takes postfix words, stalls in random bursts, and honors a
    // long hold-off when one is requested.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && postfix_valid && postfix_ready)
                postfix_model.check_postfix(postfix_word);
            if (out_hold > 0)
            begin
                out_hold--;
                postfix_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                postfix_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                postfix_ready <= 1'b0;
            end
            else
            begin
                postfix_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without a word moving on either channel.
    always @(posedge clk)
    begin
        if ((infix_valid && infix_ready) || (postfix_valid && postfix_ready))
        begin
            idle_cycles = 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            idle_cycles++;
        end
    end

    initial
    begin
        int pick;
        postfix_model = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // End on an empty stack gives nothing.
        send_end(8'hFF);
        // Extreme digits, every operator, ignored characters, a right
        // associative looking chain of carets and a parenthesized group.
        send_char(CH_ZERO);
        send_char(8'h00);
        send_char(CH_PLUS);
        send_char(CH_NINE);
        send_char(CH_MINUS);
        send_char(8'hFF);
        send_char(CH_LPAREN);
        send_char(CH_ZERO + 8'd1);
        send_char(CH_STAR);
        send_char(CH_ZERO + 8'd2);
        send_char(CH_SLASH);
        send_char(CH_ZERO + 8'd3);
        send_char(CH_CARET);
        send_char(CH_ZERO + 8'd4);
        send_char(CH_CARET);
        send_char(CH_ZERO + 8'd5);
        send_char(CH_RPAREN);
        send_char(CH_CARET);
        send_char(CH_ZERO + 8'd6);
        send_end(8'h00);
        // Closing parenthesis with an empty stack, then one that must pop
        // an operator before it finds no partner.
        send_char(CH_RPAREN);
        send_char(CH_ZERO + 8'd7);
        send_char(CH_PLUS);
        send_char(CH_ZERO + 8'd8);
        send_char(CH_RPAREN);
        // An open parenthesis left at the end is dropped quietly.
        send_char(CH_LPAREN);
        send_char(CH_ZERO + 8'd1);
        send_end(8'h5A);
        // Fill the stack, then overflow on a parenthesis and an operator.
        repeat (OP_STACK_DEPTH + 1) send_char(CH_LPAREN);
        send_char(CH_MINUS);
        send_end(8'h00);

        wait_drained();

        // Long receiver stall while the sender keeps going, so the block
        // backs up and stops taking input.
        out_hold = HOLD_CYCLES;
        no_gaps  = 1'b1;
        make_expression(40, 1'b0);
        send_expression();
        no_gaps = 1'b0;
        wait_drained();

        while (words_sent < TARGET_WORDS)
        begin
            calm = (words_sent >= CALM_AFTER);
            pick = $urandom_range(0, 19);
            if (pick < 13)
            begin
                make_expression($urandom_range(1, 24), 1'b0);
                send_expression();
            end
            else if (pick < 16)
            begin
                make_expression($urandom_range(1, 16), 1'b1);
                send_expression();
            end
            else if (pick < 19)
            begin
                // Noise: any byte, now and then an end marker.
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_end(8'($urandom_range(0, 255)));
                    else
                        send_char(8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                // Deep nesting that runs close to or past the stack size.
                repeat ($urandom_range(OP_STACK_DEPTH - 4, OP_STACK_DEPTH + 3))
                    send_char(CH_LPAREN);
                make_expression($urandom_range(1, 10), 1'b1);
                send_expression();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (postfix_model.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
design/itp_pkg.sv
design/itp_ucode_rom.sv
design/itp_sequencer.sv
design/itp_datapath.sv
design/infix_to_postfix_converter.sv
design/itp_checker.sv
test/infix_to_postfix_converter_tb.sv
